// ----- sv/assert_macros.svh -----
// Assertion macros shared by the interpolation unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define SRSI_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define SRSI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/srsi_pkg.sv -----
// Types, constants and helpers for the SIMP/RAMP stiffness interpolation unit.
package srsi_pkg;

    localparam int FRAC       = 16;             // density fraction bits
    localparam int X_W        = FRAC + 1;       // density width, Q1.FRAC
    localparam int E_W        = 32;             // e0 / span width, Q16.16
    localparam int P_W        = 4;              // exponent width
    localparam int P_MAX      = 15;             // largest exponent
    localparam int DEN_W      = X_W + P_W;      // RAMP denominator width
    localparam int QUO_W      = E_W + P_W + 1;  // divider quotient width
    localparam int NUM_W      = QUO_W + FRAC;   // divider numerator width
    localparam int OUT_W      = 48;
    localparam int DIV_STAGES = QUO_W;
    localparam int SIMP_LAT   = 3 + P_MAX;
    localparam int RAMP_LAT   = 3 + 3 * DIV_STAGES;

    localparam logic [X_W-1:0]   ONE_X   = X_W'(1) << FRAC;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef enum logic [1:0] {
        CFG_MODE = 2'd0,
        CFG_E0   = 2'd1,
        CFG_MINF = 2'd2,
        CFG_PEXP = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_SIMP = 1'b0,
        MODE_RAMP = 1'b1
    } t_mode;

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] side;
    } t_div_req;

    typedef struct packed {
        logic             valid;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] side;
    } t_div_rsp;

    typedef struct packed {
        logic             sat;
        logic [OUT_W-1:0] val;
    } t_clip;

    function automatic t_clip clip_out(input logic [63:0] v);
        t_clip r;
        if (v > 64'(OUT_MAX)) begin
            r.sat = 1'b1;
            r.val = OUT_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/srsi_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side data.
`include "assert_macros.svh"

module srsi_div_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srsi_pkg::t_div_req  i_req,
    output srsi_pkg::t_div_rsp  o_rsp
);

    localparam int NS = srsi_pkg::DIV_STAGES;
    localparam int QW = srsi_pkg::QUO_W;
    localparam int DW = srsi_pkg::DEN_W;
    localparam int NW = srsi_pkg::NUM_W;

    logic          r_v    [0:NS-1];
    logic [DW-1:0] r_rem  [0:NS-1];
    logic [QW-1:0] r_acc  [0:NS-1];
    logic [DW-1:0] r_den  [0:NS-1];
    logic [NW-1:0] r_side [0:NS-1];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic          s_v;
        logic [DW-1:0] s_rem;
        logic [QW-1:0] s_acc;
        logic [DW-1:0] s_den;
        logic [NW-1:0] s_side;
        logic [DW:0]   w_try;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_acc;

        if (j == 0) begin : g_src_in
            assign s_v    = i_req.valid;
            assign s_rem  = DW'(i_req.num[NW-1:QW]);
            assign s_acc  = i_req.num[QW-1:0];
            assign s_den  = i_req.den;
            assign s_side = i_req.side;
        end else begin : g_src_prev
            assign s_v    = r_v[j-1];
            assign s_rem  = r_rem[j-1];
            assign s_acc  = r_acc[j-1];
            assign s_den  = r_den[j-1];
            assign s_side = r_side[j-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign w_try = {s_rem, s_acc[QW-1]};
        assign w_ge  = (w_try >= {1'b0, s_den});
        assign n_rem = w_ge ? DW'(w_try - {1'b0, s_den}) : DW'(w_try);
        assign n_acc = {s_acc[QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= s_v;
            end
            r_rem[j]  <= n_rem;
            r_acc[j]  <= n_acc;
            r_den[j]  <= s_den;
            r_side[j] <= s_side;
        end
    end

    assign o_rsp.valid = r_v[NS-1];
    assign o_rsp.quo   = r_acc[NS-1];
    assign o_rsp.den   = r_den[NS-1];
    assign o_rsp.side  = r_side[NS-1];

    `SRSI_ASSERT_CLK(a_rem_below_den, r_v[NS-1] |-> (r_rem[NS-1] < r_den[NS-1]), "divider remainder not below divisor")

endmodule

// ----- sv/simp_ramp_stiffness_interpolation_unit.sv -----
// Top level of the SIMP/RAMP stiffness interpolation unit.
//
//  channel   direction  handshake                     payload
//  request   in         start / busy                  i_density
//  result    out        o_strobe (one cycle)          o_stiffness, o_stiffness_slope, o_saturated
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
//  One request per cycle is taken while busy is low. A SIMP result passes the input
//  register, the 15-stage power chain, the scaling stage and the output register in turn.
//  A RAMP result passes the input and front-end registers, three chained 37-stage
//  bit-per-stage dividers and the output register. Only the chain of the active mode
//  carries valid bits. A config write, and reset, hold busy high while the derived Emin
//  and span terms settle. Reset is synchronous and clears all valid bits and the config
//  registers; the receiver cannot stall, so nothing holds.
`include "assert_macros.svh"

module simp_ramp_stiffness_interpolation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] i_density,
    output logic        o_strobe,
    output logic [47:0] o_stiffness,
    output logic [47:0] o_stiffness_slope,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int FRAC  = srsi_pkg::FRAC;
    localparam int XW    = srsi_pkg::X_W;
    localparam int EW    = srsi_pkg::E_W;
    localparam int PW    = srsi_pkg::P_W;
    localparam int NP    = srsi_pkg::P_MAX;
    localparam int DW    = srsi_pkg::DEN_W;
    localparam int QW    = srsi_pkg::QUO_W;
    localparam int NW    = srsi_pkg::NUM_W;
    localparam int OW    = srsi_pkg::OUT_W;
    localparam int MEW   = EW + XW;        // span * power
    localparam int PSW   = EW + PW;        // p * span
    localparam int MDW   = PSW + XW;       // p * span * power
    localparam int SL    = srsi_pkg::SIMP_LAT;
    localparam int RL    = srsi_pkg::RAMP_LAT;

    // ---------------------------------------------------------------- config
    srsi_pkg::t_mode r_mode;
    logic [EW-1:0]   r_e0;
    logic [EW-1:0]   r_minf;
    logic [PW-1:0]   r_pexp;
    logic [1:0]      r_hold;
    logic            cfg_wr;
    logic            accept;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign busy        = (r_hold != 2'd0);
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= srsi_pkg::MODE_SIMP;
            r_e0   <= 32'd65536;
            r_minf <= 32'd4;
            r_pexp <= 4'd3;
            r_hold <= 2'd3;
        end else begin
            if (cfg_wr) begin
                case (srsi_pkg::t_cfg_idx'(i_cfg_index))
                    srsi_pkg::CFG_MODE: r_mode <= srsi_pkg::t_mode'(i_cfg_data[0]);
                    srsi_pkg::CFG_E0:   r_e0   <= i_cfg_data;
                    srsi_pkg::CFG_MINF: r_minf <= i_cfg_data;
                    srsi_pkg::CFG_PEXP: r_pexp <= i_cfg_data[PW-1:0];
                    default: ;
                endcase
            end
            // hold off requests until the derived terms below have settled
            if (cfg_wr) begin
                r_hold <= 2'd3;
            end else if (r_hold != 2'd0) begin
                r_hold <= r_hold - 2'd1;
            end
        end
    end

    // Derived terms: Emin, span, p*span, (1+p)*span. Stable while requests flow.
    logic [2*EW-1:0] r_prod;
    logic [EW-1:0]   r_emin;
    logic [EW-1:0]   r_span;
    logic [PSW-1:0]  r_pspan;
    logic [QW-1:0]   r_p1span;

    always_ff @(posedge i_clk) begin
        r_prod   <= (2*EW)'(r_e0) * (2*EW)'(r_minf);
        r_emin   <= r_prod[2*EW-1:EW];
        r_span   <= r_e0 - r_prod[2*EW-1:EW];
        r_pspan  <= PSW'(r_span) * PSW'(r_pexp);
        r_p1span <= QW'(r_span) * (QW'(r_pexp) + QW'(1));
    end

    // ---------------------------------------------------------- input stage
    logic          r_v0;
    logic [XW-1:0] r_x0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= accept;
        end
        // clamp density to full material
        r_x0 <= (i_density > srsi_pkg::ONE_X) ? srsi_pkg::ONE_X : i_density;
    end

    // ---------------------------------------------------- SIMP power chain
    // Stage k multiplies once more by x while k is below the exponent, and
    // keeps the previous power alongside for the slope.
    logic          r_sv [0:NP-1];
    logic [XW-1:0] r_sx [0:NP-1];
    logic [XW-1:0] r_pw [0:NP-1];
    logic [XW-1:0] r_pp [0:NP-1];

    for (genvar k = 0; k < NP; k++) begin : g_pow
        logic            s_v;
        logic [XW-1:0]   s_x;
        logic [XW-1:0]   s_pw;
        logic [XW-1:0]   s_pp;
        logic [2*XW-1:0] w_mul;
        logic            w_on;

        if (k == 0) begin : g_src_in
            // admit only requests taken under the power law
            assign s_v  = r_v0 && (r_mode == srsi_pkg::MODE_SIMP);
            assign s_x  = r_x0;
            assign s_pw = srsi_pkg::ONE_X;
            assign s_pp = srsi_pkg::ONE_X;
        end else begin : g_src_prev
            assign s_v  = r_sv[k-1];
            assign s_x  = r_sx[k-1];
            assign s_pw = r_pw[k-1];
            assign s_pp = r_pp[k-1];
        end

        assign w_mul = (2*XW)'(s_pw) * (2*XW)'(s_x);
        assign w_on  = (PW'(k) < r_pexp);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else begin
                r_sv[k] <= s_v;
            end
            r_sx[k] <= s_x;
            r_pw[k] <= w_on ? w_mul[FRAC+XW-1:FRAC] : s_pw;
            r_pp[k] <= w_on ? s_pw : s_pp;
        end
    end

    // scale by span and p*span
    logic           r_mv;
    logic [MEW-1:0] r_me;
    logic [MDW-1:0] r_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_sv[NP-1];
        end
        r_me <= MEW'(r_span) * MEW'(r_pw[NP-1]);
        r_md <= MDW'(r_pspan) * MDW'(r_pp[NP-1]);
    end

    // add Emin, clip, register the SIMP result
    logic            r_so_v;
    logic [OW-1:0]   r_so_e;
    logic [OW-1:0]   r_so_d;
    logic            r_so_sat;
    srsi_pkg::t_clip s_ce;
    srsi_pkg::t_clip s_cd;

    assign s_ce = srsi_pkg::clip_out(64'(r_emin) + 64'(r_me[MEW-1:FRAC]));
    assign s_cd = srsi_pkg::clip_out(64'(r_md[MDW-1:FRAC]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_so_v <= 1'b0;
        end else begin
            r_so_v <= r_mv;
        end
        r_so_e   <= s_ce.val;
        r_so_d   <= s_cd.val;
        r_so_sat <= s_ce.sat | s_cd.sat;
    end

    // ---------------------------------------------------- RAMP front end
    // den = ONE + p*(ONE-x), num1 = span*x, num2 = (1+p)*span*ONE
    logic          r_rv1;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_num1;
    logic [NW-1:0] r_num2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv1 <= 1'b0;
        end else begin
            // admit only requests taken under the rational law
            r_rv1 <= r_v0 && (r_mode == srsi_pkg::MODE_RAMP);
        end
        r_den  <= DW'(srsi_pkg::ONE_X) + DW'(r_pexp) * DW'(srsi_pkg::ONE_X - r_x0);
        r_num1 <= NW'(r_span) * NW'(r_x0);
        r_num2 <= {r_p1span, FRAC'(0)};
    end

    // h = num2/den, then slope = h*ONE/den, then q1 = num1/den
    srsi_pkg::t_div_req d1_req, d2_req, d3_req;
    srsi_pkg::t_div_rsp d1_rsp, d2_rsp, d3_rsp;

    assign d1_req.valid = r_rv1;
    assign d1_req.num   = r_num2;
    assign d1_req.den   = r_den;
    assign d1_req.side  = r_num1;

    srsi_div_pipe u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (d1_req),
        .o_rsp   (d1_rsp)
    );

    assign d2_req.valid = d1_rsp.valid;
    assign d2_req.num   = {d1_rsp.quo, FRAC'(0)};
    assign d2_req.den   = d1_rsp.den;
    assign d2_req.side  = d1_rsp.side;

    srsi_div_pipe u_div_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (d2_req),
        .o_rsp   (d2_rsp)
    );

    assign d3_req.valid = d2_rsp.valid;
    assign d3_req.num   = d2_rsp.side;
    assign d3_req.den   = d2_rsp.den;
    assign d3_req.side  = NW'(d2_rsp.quo);

    srsi_div_pipe u_div_stiff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (d3_req),
        .o_rsp   (d3_rsp)
    );

    // add Emin, clip, register the RAMP result
    logic            r_ro_v;
    logic [OW-1:0]   r_ro_e;
    logic [OW-1:0]   r_ro_d;
    logic            r_ro_sat;
    srsi_pkg::t_clip s_re;
    srsi_pkg::t_clip s_rd;

    assign s_re = srsi_pkg::clip_out(64'(r_emin) + 64'(d3_rsp.quo));
    assign s_rd = srsi_pkg::clip_out(64'(d3_rsp.side[QW-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ro_v <= 1'b0;
        end else begin
            r_ro_v <= d3_rsp.valid;
        end
        r_ro_e   <= s_re.val;
        r_ro_d   <= s_rd.val;
        r_ro_sat <= s_re.sat | s_rd.sat;
    end

    // ------------------------------------------------------------ outputs
    // user makes mode changes only while idle (unchecked) so the select never splits a stream
    always_comb begin
        if (r_mode == srsi_pkg::MODE_RAMP) begin
            o_strobe          = r_ro_v;
            o_stiffness       = r_ro_e;
            o_stiffness_slope = r_ro_d;
            o_saturated       = r_ro_sat;
        end else begin
            o_strobe          = r_so_v;
            o_stiffness       = r_so_e;
            o_stiffness_slope = r_so_d;
            o_saturated       = r_so_sat;
        end
    end

    `SRSI_ASSERT_CLK(a_cfg_holds_off, cfg_wr |=> busy, "request window open after config write")
    `SRSI_ASSERT_CLK(a_simp_latency, r_so_v |-> $past(accept && i_rst_n, SL), "stray SIMP result")
    `SRSI_ASSERT_CLK(a_ramp_latency, r_ro_v |-> $past(accept && i_rst_n, RL), "stray RAMP result")
    `SRSI_ASSERT_RST(a_quiet_after_reset, !i_rst_n |=> !o_strobe, "result strobe after reset")

endmodule

// ----- test/tb_simp_ramp_stiffness_interpolation_unit.sv -----
// Self-checking testbench for the SIMP/RAMP stiffness interpolation unit.
module tb_simp_ramp_stiffness_interpolation_unit;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [16:0] i_density;
    logic        o_strobe;
    logic [47:0] o_stiffness;
    logic [47:0] o_stiffness_slope;
    logic        o_saturated;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    simp_ramp_stiffness_interpolation_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_density         (i_density),
        .o_strobe          (o_strobe),
        .o_stiffness       (o_stiffness),
        .o_stiffness_slope (o_stiffness_slope),
        .o_saturated       (o_saturated),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    typedef struct {
        logic [47:0] stiff;
        logic [47:0] slope;
        logic        sat;
    } t_stiff_res;

    // one directed request, with the settings it runs under
    typedef struct {
        srsi_pkg::t_mode mode;
        logic [31:0]     e0;
        logic [31:0]     minf;
        logic [3:0]      pexp;
        logic [16:0]     dens;
        bit              typed;
        t_stiff_res      want;
    } t_dir_row;

    // testbench's own copy of the configuration registers
    srsi_pkg::t_mode cur_mode;
    logic [31:0]     cur_e0;
    logic [31:0]     cur_minf;
    logic [3:0]      cur_pexp;

    t_stiff_res  pending_stiff[$];   // predicted results, oldest first
    bit          typed_flag[$];      // typed rows carry their own answer
    t_stiff_res  typed_res[$];
    t_dir_row    dir_rows[$];
    int          n_errors;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the result stream dries up
    initial begin
        #5ms;
        $display("simp_ramp_stiffness_interpolation_unit: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // clip to 48 bits and flag it
    function automatic logic [47:0] clip48(input bit [63:0] v, inout logic sat);
        if (v > 64'(srsi_pkg::OUT_MAX)) begin
            sat = 1'b1;
            return srsi_pkg::OUT_MAX;
        end
        return v[47:0];
    endfunction

    // compute stiffness and slope for one density under the current settings
    function automatic t_stiff_res predict_stiffness(input logic [16:0] dens);
        bit [63:0]  x, p, emin, span, e_v, de_v, pw, pw_prev, den, h;
        t_stiff_res r;
        logic       sat;
        sat  = 1'b0;
        x    = 64'(dens);
        p    = 64'(cur_pexp);
        if (x > 64'(srsi_pkg::ONE_X)) x = 64'(srsi_pkg::ONE_X);
        emin = (64'(cur_e0) * 64'(cur_minf)) >> 32;
        span = 64'(cur_e0) - emin;
        if (cur_mode == srsi_pkg::MODE_SIMP) begin
            pw      = 64'(srsi_pkg::ONE_X);
            pw_prev = 64'(srsi_pkg::ONE_X);
            for (int k = 0; k < int'(p); k++) begin
                pw_prev = pw;
                pw      = (pw * x) >> srsi_pkg::FRAC;
            end
            e_v  = emin + ((span * pw) >> srsi_pkg::FRAC);
            de_v = (p == 0) ? 64'd0 : ((p * span * pw_prev) >> srsi_pkg::FRAC);
        end else begin
            den  = 64'(srsi_pkg::ONE_X) + p * (64'(srsi_pkg::ONE_X) - x);
            e_v  = emin + (span * x) / den;
            h    = (span * (p + 1) * 64'(srsi_pkg::ONE_X)) / den;
            de_v = (h * 64'(srsi_pkg::ONE_X)) / den;
        end
        r.stiff = clip48(e_v, sat);
        r.slope = clip48(de_v, sat);
        r.sat   = sat;
        return r;
    endfunction

    // Monitor: check strobed results, then log accepted requests and
    // register writes. Inputs only move on the falling edge, so the
    // values seen here are settled.
    always @(posedge i_clk) begin
        t_stiff_res want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_stiff.size() == 0) begin
                    report_mismatch("result strobed with nothing outstanding");
                end else begin
                    want = pending_stiff.pop_front();
                    if (o_stiffness !== want.stiff)
                        report_mismatch($sformatf("stiffness %0h, want %0h",
                                                  o_stiffness, want.stiff));
                    if (o_stiffness_slope !== want.slope)
                        report_mismatch($sformatf("slope %0h, want %0h",
                                                  o_stiffness_slope, want.slope));
                    if (o_saturated !== want.sat)
                        report_mismatch($sformatf("saturated %0b, want %0b",
                                                  o_saturated, want.sat));
                end
            end
            if (start && !busy) begin
                want = predict_stiffness(i_density);
                // a typed row replaces the prediction with its own answer
                if (typed_flag.size() != 0 && typed_flag.pop_front()) begin
                    want = typed_res.pop_front();
                end
                pending_stiff.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (srsi_pkg::t_cfg_idx'(i_cfg_index))
                    srsi_pkg::CFG_MODE: cur_mode = srsi_pkg::t_mode'(i_cfg_data[0]);
                    srsi_pkg::CFG_E0:   cur_e0   = i_cfg_data;
                    srsi_pkg::CFG_MINF: cur_minf = i_cfg_data;
                    srsi_pkg::CFG_PEXP: cur_pexp = i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    // Drive one request; entered and left on a falling edge with start high.
    task automatic send_request(input logic [16:0] dens, input bit typed, input t_stiff_res res);
        typed_flag.push_back(typed);
        if (typed) typed_res.push_back(res);
        start     <= 1'b1;
        i_density <= dens;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Let every outstanding request come back before touching registers.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_stiff.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Present one write; valid stays high on return and the caller drops it.
    task automatic write_reg(input srsi_pkg::t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Program all four registers; spare data bits are random to exercise masking.
    task automatic program_unit(input srsi_pkg::t_mode mode, input logic [31:0] e0,
                                input logic [31:0] minf, input logic [3:0] pexp);
        drain_results();
        write_reg(srsi_pkg::CFG_MODE, {31'($urandom_range(0, 32'h7fff_ffff)), mode});
        write_reg(srsi_pkg::CFG_E0,   e0);
        write_reg(srsi_pkg::CFG_MINF, minf);
        write_reg(srsi_pkg::CFG_PEXP, {28'($urandom_range(0, 32'h0fff_ffff)), pexp});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input srsi_pkg::t_mode mode, input logic [31:0] e0,
                           input logic [31:0] minf,
                           input logic [3:0] pexp, input logic [16:0] dens, input bit typed,
                           input logic [47:0] stiff, input logic [47:0] slope);
        t_dir_row row;
        row.mode = mode; row.e0 = e0; row.minf = minf; row.pexp = pexp;
        row.dens = dens; row.typed = typed;
        row.want.stiff = stiff; row.want.slope = slope; row.want.sat = 1'b0;
        dir_rows.push_back(row);
    endtask

    function automatic logic [16:0] rand_density();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return 17'd0;
            1:       return 17'(srsi_pkg::ONE_X);
            2:       return 17'($urandom_range(65537, 131071));  // above full, clamped
            3:       return 17'($urandom_range(0, 255));
            4:       return 17'($urandom_range(65280, 65536));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0:       return 32'd0;
            1:       return 32'hffff_ffff;
            2:       return 32'($urandom_range(0, 32'h0003_ffff));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_stiff_res nores;
        int         burst;
        logic [3:0] pexp;
        nores       = '{default: '0};
        start       = 1'b0;
        i_density   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = srsi_pkg::CFG_MODE;
        i_cfg_data  = '0;
        n_errors    = 0;
        cur_mode    = srsi_pkg::MODE_SIMP;
        cur_e0      = 32'd65536;
        cur_minf    = 32'd4;
        cur_pexp    = 4'd3;
        i_rst_n     = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: reset settings first, then the corners of both laws.
        add_row(srsi_pkg::MODE_SIMP, 32'd65536, 32'd4, 4'd3, 17'd0,     1, 48'd0, 48'd0);
        add_row(srsi_pkg::MODE_SIMP, 32'd65536, 32'd4, 4'd3, 17'd65536, 1, 48'd65536,
                48'd196608);
        add_row(srsi_pkg::MODE_SIMP, 32'd65536, 32'd4, 4'd3, 17'h1ffff, 1, 48'd65536,
                48'd196608);
        add_row(srsi_pkg::MODE_SIMP, 32'd65536, 32'd4, 4'd3, 17'd1,     0, '0, '0);
        add_row(srsi_pkg::MODE_SIMP, 32'd65536, 32'd4, 4'd3, 17'd32768, 0, '0, '0);
        add_row(srsi_pkg::MODE_SIMP, '1, 32'd0, 4'd1, 17'd65536, 1, 48'hffff_ffff,
                48'hffff_ffff);
        add_row(srsi_pkg::MODE_SIMP, '1, 32'd0, 4'd1, 17'd0,     1, 48'd0, 48'hffff_ffff);
        add_row(srsi_pkg::MODE_SIMP, '1, '1, 4'd15, 17'd65536,   0, '0, '0);
        add_row(srsi_pkg::MODE_SIMP, '1, '1, 4'd15, 17'd0,       0, '0, '0);
        add_row(srsi_pkg::MODE_SIMP, '1, '1, 4'd15, 17'd40000,   0, '0, '0);
        // exponent zero: stiffness stays at e0, slope vanishes
        add_row(srsi_pkg::MODE_SIMP, 32'd65536, 32'd0, 4'd0, 17'd12345, 1, 48'd65536, 48'd0);
        add_row(srsi_pkg::MODE_RAMP, 32'd65536, 32'd0, 4'd3, 17'd65536, 1, 48'd65536,
                48'd262144);
        add_row(srsi_pkg::MODE_RAMP, 32'd65536, 32'd0, 4'd3, 17'd0,     1, 48'd0, 48'd16384);
        add_row(srsi_pkg::MODE_RAMP, '1, 32'd0, 4'd15, 17'd0,      0, '0, '0);
        add_row(srsi_pkg::MODE_RAMP, '1, 32'd0, 4'd15, 17'd65536,  0, '0, '0);
        add_row(srsi_pkg::MODE_RAMP, '1, 32'd0, 4'd15, 17'h1ffff,  0, '0, '0);
        add_row(srsi_pkg::MODE_RAMP, '1, '1, 4'd15, 17'd30000,     0, '0, '0);
        add_row(srsi_pkg::MODE_RAMP, 32'd1, 32'd0, 4'd7, 17'd777,  0, '0, '0);
        // exponent zero under RAMP: a straight line
        add_row(srsi_pkg::MODE_RAMP, 32'd65536, 32'd0, 4'd0, 17'd32768, 1, 48'd32768,
                48'd65536);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != cur_mode || dir_rows[i].e0 != cur_e0 ||
                dir_rows[i].minf != cur_minf || dir_rows[i].pexp != cur_pexp) begin
                program_unit(dir_rows[i].mode, dir_rows[i].e0, dir_rows[i].minf,
                             dir_rows[i].pexp);
            end
            send_request(dir_rows[i].dens, dir_rows[i].typed, dir_rows[i].want);
            if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 3));
        end

        // Random phases, each under fresh settings.
        for (int ph = 0; ph < 12; ph++) begin
            pexp = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 15));
            if (ph == 0) pexp = 4'd15;
            if (ph == 1) pexp = 4'd1;
            program_unit(srsi_pkg::t_mode'(ph % 2), rand_word(), rand_word(), pexp);
            for (int n = 0; n < 96; ) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 96; b++, n++)
                    send_request(rand_density(), 0, nores);
                if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
                // now and then, midway through a phase, hold until the pipe is empty
                if (n > 40 && n < 60 && $urandom_range(0, 4) == 0) drain_results();
            end
        end

        drain_results();
        repeat (150) @(negedge i_clk);
        if (n_errors == 0 && pending_stiff.size() == 0) begin
            $display("simp_ramp_stiffness_interpolation_unit: match");
        end else begin
            $display("simp_ramp_stiffness_interpolation_unit: mismatch");
        end
        $finish;
    end

endmodule
